/* design/stop_and_wait_datagram_link_assert.svh */
// Assertion macros shared by the stop-and-wait datagram link RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef STOP_AND_WAIT_DATAGRAM_LINK_ASSERT_SVH
`define STOP_AND_WAIT_DATAGRAM_LINK_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define SWDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SWDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SWDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SWDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/swdl_pkg.sv */
// Shared types and codes for the stop-and-wait datagram link.
// No dependencies; used by swdl_buf and stop_and_wait_datagram_link.
`timescale 1ns / 1ps
package swdl_pkg;

	// Event kinds carried on s_tuser.
	localparam logic [2:0] KIND_DGRAM = 3'd0;
	localparam logic [2:0] KIND_SEND  = 3'd1;
	localparam logic [2:0] KIND_OPEN  = 3'd2;
	localparam logic [2:0] KIND_TICK  = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	// Header type byte of a received datagram.
	localparam logic [7:0] DT_DATA  = 8'd0;
	localparam logic [7:0] DT_ACK   = 8'd1;
	localparam logic [7:0] DT_HELLO = 8'd2;

	// Type of a datagram to transmit.
	localparam logic [1:0] TX_DATA  = 2'd0;
	localparam logic [1:0] TX_ACK   = 2'd1;
	localparam logic [1:0] TX_HELLO = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_ACKED   = 2'd1;
	localparam logic [1:0] ST_GAVE_UP = 2'd2;
	localparam logic [1:0] ST_BUSY    = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_PEER_ADDRESS     = 3'd0;
	localparam logic [2:0] CFG_OWN_UDP          = 3'd1;
	localparam logic [2:0] CFG_PEER_UDP         = 3'd2;
	localparam logic [2:0] CFG_RETRANSMIT_TICKS = 3'd3;
	localparam logic [2:0] CFG_MAX_TRIES        = 3'd4;

	localparam logic [31:0] RETRANSMIT_TICKS_RST = 32'd25000000;
	localparam logic [7:0]  MAX_TRIES_RST        = 8'd200;
	localparam logic [15:0] HEADER_BYTES         = 16'd5;

	localparam int DEF_BUFFER_BYTES = 16384;
	localparam int DEF_CHUNK_BYTES  = 1024;

	// Input payload, last declared field (src_ip) in the lowest bits.
	typedef struct packed {
		logic [15:0] request_length;
		logic [31:0] dgram_seq;
		logic [7:0]  dgram_type;
		logic [15:0] dgram_length;
		logic [15:0] dst_udp;
		logic [15:0] src_udp;
		logic [31:0] src_ip;
	} in_item_t;

	// Result payload, last declared field (tx_valid) in the lowest bits, padded to whole bytes.
	typedef struct packed {
		logic        pad;
		logic [1:0]  status;
		logic [14:0] read_count;
		logic [13:0] read_offset;
		logic [10:0] store_length;
		logic [13:0] store_offset;
		logic        store_valid;
		logic [10:0] tx_payload_length;
		logic [31:0] tx_sequence;
		logic [1:0]  tx_type;
		logic        tx_valid;
	} result_t;

	// Commands from the protocol logic to the receive buffer pointers.
	typedef struct packed {
		logic        store_en;
		logic [10:0] store_len;
		logic        read_en;
		logic [15:0] read_len;
	} buf_cmd_t;

endpackage

/* design/swdl_buf.sv */
// Receive buffer bookkeeping: write and read pointers into external memory.
// Depends on swdl_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "stop_and_wait_datagram_link_assert.svh"
module swdl_buf
	import swdl_pkg::*;
#(
	parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
	localparam int PTR_W = $clog2(BUFFER_BYTES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  buf_cmd_t         cmd,
	output logic [PTR_W-1:0] room,
	output logic [13:0]      wr_offset,
	output logic [13:0]      rd_offset,
	output logic [14:0]      rd_count
);

	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W-1:0] avail;
	logic [PTR_W-1:0] rd_grant;
	logic [PTR_W-1:0] rd_next;

	// The write pointer never passes the buffer size, so room never goes negative.
	assign room      = PTR_W'(BUFFER_BYTES) - wr_q;
	assign avail     = (wr_q > rd_q) ? (wr_q - rd_q) : '0;
	assign rd_grant  = (32'(avail) < 32'(cmd.read_len)) ? avail : PTR_W'(cmd.read_len);
	assign rd_next   = rd_q + rd_grant;
	assign wr_offset = 14'(wr_q);
	assign rd_offset = (avail != '0) ? 14'(rd_q) : '0;
	assign rd_count  = (avail != '0) ? 15'(rd_grant) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else if (cmd.store_en) begin
			wr_q <= wr_q + PTR_W'(cmd.store_len);
		end else if (cmd.read_en && avail != '0) begin
			// A read that drains the buffer rewinds both pointers to the start.
			if (rd_next == wr_q) begin
				wr_q <= '0;
				rd_q <= '0;
			end else begin
				rd_q <= rd_next;
			end
		end
	end

	`SWDL_ASSERT_IMP(a_rd_not_past_wr, clk, arst_n, 1'b1, rd_q <= wr_q, "read pointer passed write pointer")
	`SWDL_ASSERT_IMP(a_wr_in_buffer, clk, arst_n, 1'b1, 32'(wr_q) <= 32'(BUFFER_BYTES), "write pointer beyond buffer")
	`SWDL_ASSERT_IMP(a_store_fits, clk, arst_n, cmd.store_en, 32'(cmd.store_len) <= 32'(room), "store without room")

endmodule

/* design/stop_and_wait_datagram_link.sv */
// Stop-and-wait reliable stream engine over datagrams.
// Each result is registered and appears in the cycle after its event transfer.
// Throughput: one event per clock while results are taken; while a result is held,
// s_tready follows m_tready. arst_n clears all protocol state and the result valid
// and loads the register defaults (retransmit ticks 25000000, max tries 200).
// Depends on swdl_pkg, swdl_buf and the shared assertion macro header.
`timescale 1ns / 1ps
`include "stop_and_wait_datagram_link_assert.svh"
module stop_and_wait_datagram_link
	import swdl_pkg::*;
#(
	parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
	parameter int CHUNK_BYTES  = DEF_CHUNK_BYTES,
	localparam int PTR_W = $clog2(BUFFER_BYTES + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// src_ip, src_udp, dst_udp, dgram_length, dgram_type, dgram_seq, request_length
	input  logic [135:0] s_tdata,
	// kind
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tx_valid, tx_type, tx_sequence, tx_payload_length, store_valid, store_offset,
	// store_length, read_offset, read_count, status, then one zero pad bit
	output logic [103:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	in_item_t in_item;
	result_t  res;
	result_t  res_q;
	logic     m_tvalid_q;
	logic     take;

	logic [31:0] peer_address_q;
	logic [15:0] own_udp_q;
	logic [15:0] peer_udp_q;
	logic [31:0] retransmit_ticks_q;
	logic [7:0]  max_tries_q;

	logic [31:0] send_seq_q, send_seq_d;
	logic        awaiting_q, awaiting_d;
	logic        is_hello_q, is_hello_d;
	logic [10:0] pending_len_q, pending_len_d;
	logic [31:0] elapsed_q, elapsed_d;
	logic [7:0]  sends_q, sends_d;
	logic [31:0] rx_expected_q, rx_expected_d;

	buf_cmd_t         buf_cmd;
	logic [PTR_W-1:0] room;
	logic [13:0]      wr_offset;
	logic [13:0]      rd_offset;
	logic [14:0]      rd_count;

	logic        dg_match;
	logic [15:0] data_len;
	logic [10:0] send_len;
	logic        timed_out;

	assign in_item  = in_item_t'(s_tdata);
	assign s_tready = !m_tvalid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_q;

	assign dg_match = (in_item.src_ip == peer_address_q) && (in_item.src_udp == peer_udp_q)
		&& (in_item.dst_udp == own_udp_q) && (in_item.dgram_length >= HEADER_BYTES);
	assign data_len  = in_item.dgram_length - HEADER_BYTES;
	assign send_len  = (in_item.request_length < 16'(CHUNK_BYTES))
		? in_item.request_length[10:0] : 11'(CHUNK_BYTES);
	assign timed_out = ({1'b0, elapsed_q} + 33'd1) >= {1'b0, retransmit_ticks_q};

	swdl_buf #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (buf_cmd),
		.room     (room),
		.wr_offset(wr_offset),
		.rd_offset(rd_offset),
		.rd_count (rd_count)
	);

	always_comb begin
		res           = '0;
		buf_cmd       = '0;
		send_seq_d    = send_seq_q;
		awaiting_d    = awaiting_q;
		is_hello_d    = is_hello_q;
		pending_len_d = pending_len_q;
		elapsed_d     = elapsed_q;
		sends_d       = sends_q;
		rx_expected_d = rx_expected_q;
		unique case (s_tuser)
			KIND_DGRAM: begin
				if (dg_match && in_item.dgram_type == DT_ACK) begin
					if (awaiting_q && in_item.dgram_seq == send_seq_q) begin
						awaiting_d = 1'b0;
						is_hello_d = 1'b0;
						res.status = ST_ACKED;
					end
				end else if (dg_match && in_item.dgram_type == DT_DATA) begin
					if (in_item.dgram_seq == rx_expected_q) begin
						// In-order data is taken only whole; otherwise the peer retries.
						if (data_len != '0 && data_len <= 16'(CHUNK_BYTES)
							&& 32'(data_len) <= 32'(room)) begin
							buf_cmd.store_en  = take;
							buf_cmd.store_len = data_len[10:0];
							res.store_valid   = 1'b1;
							res.store_offset  = wr_offset;
							res.store_length  = data_len[10:0];
							rx_expected_d     = rx_expected_q + 32'd1;
							res.tx_valid      = 1'b1;
							res.tx_type       = TX_ACK;
							res.tx_sequence   = in_item.dgram_seq;
						end
					end else if (in_item.dgram_seq == rx_expected_q - 32'd1) begin
						// Our earlier ACK was lost: acknowledge the repeat again.
						res.tx_valid    = 1'b1;
						res.tx_type     = TX_ACK;
						res.tx_sequence = in_item.dgram_seq;
					end
				end
			end
			KIND_SEND: begin
				if (awaiting_q) begin
					res.status = ST_BUSY;
				end else if (send_len != '0) begin
					send_seq_d            = send_seq_q + 32'd1;
					awaiting_d            = 1'b1;
					is_hello_d            = 1'b0;
					pending_len_d         = send_len;
					elapsed_d             = '0;
					sends_d               = 8'd1;
					res.tx_valid          = 1'b1;
					res.tx_type           = TX_DATA;
					res.tx_sequence       = send_seq_q + 32'd1;
					res.tx_payload_length = send_len;
				end
			end
			KIND_OPEN: begin
				if (awaiting_q) begin
					res.status = ST_BUSY;
				end else begin
					send_seq_d      = '0;
					awaiting_d      = 1'b1;
					is_hello_d      = 1'b1;
					pending_len_d   = '0;
					elapsed_d       = '0;
					sends_d         = 8'd1;
					res.tx_valid    = 1'b1;
					res.tx_type     = TX_HELLO;
					res.tx_sequence = '0;
				end
			end
			KIND_TICK: begin
				if (awaiting_q && timed_out) begin
					elapsed_d = '0;
					if (sends_q >= max_tries_q) begin
						awaiting_d = 1'b0;
						is_hello_d = 1'b0;
						res.status = ST_GAVE_UP;
					end else begin
						sends_d               = sends_q + 8'd1;
						res.tx_valid          = 1'b1;
						res.tx_type           = is_hello_q ? TX_HELLO : TX_DATA;
						res.tx_sequence       = send_seq_q;
						res.tx_payload_length = is_hello_q ? 11'd0 : pending_len_q;
					end
				end else if (awaiting_q) begin
					elapsed_d = elapsed_q + 32'd1;
				end
			end
			KIND_READ: begin
				buf_cmd.read_en  = take;
				buf_cmd.read_len = in_item.request_length;
				res.read_offset  = rd_offset;
				res.read_count   = rd_count;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_seq_q    <= '0;
			awaiting_q    <= 1'b0;
			is_hello_q    <= 1'b0;
			pending_len_q <= '0;
			elapsed_q     <= '0;
			sends_q       <= '0;
			rx_expected_q <= '0;
		end else if (take) begin
			send_seq_q    <= send_seq_d;
			awaiting_q    <= awaiting_d;
			is_hello_q    <= is_hello_d;
			pending_len_q <= pending_len_d;
			elapsed_q     <= elapsed_d;
			sends_q       <= sends_d;
			rx_expected_q <= rx_expected_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_address_q     <= '0;
			own_udp_q          <= '0;
			peer_udp_q         <= '0;
			retransmit_ticks_q <= RETRANSMIT_TICKS_RST;
			max_tries_q        <= MAX_TRIES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PEER_ADDRESS:     peer_address_q     <= cfg_data;
				CFG_OWN_UDP:          own_udp_q          <= cfg_data[15:0];
				CFG_PEER_UDP:         peer_udp_q         <= cfg_data[15:0];
				CFG_RETRANSMIT_TICKS: retransmit_ticks_q <= cfg_data;
				CFG_MAX_TRIES:        max_tries_q        <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	`SWDL_ASSERT_IMP(a_hello_needs_wait, clk, arst_n, is_hello_q, awaiting_q,
		"HELLO flag set with nothing outstanding")
	`SWDL_ASSERT_IMP(a_sends_counted, clk, arst_n, awaiting_q, sends_q != 8'd0,
		"outstanding datagram with zero sends")
	`SWDL_ASSERT_NXT(a_busy_reject, clk, arst_n, take && s_tuser == KIND_SEND && awaiting_q,
		m_tvalid && res_q.status == ST_BUSY, "send while outstanding not rejected")

endmodule
